// ===== rtl/touch_average_clamp_scale_assert.svh =====
// assertion macros for the touch averaging block
// expects clk and rst_n in the scope where the macros are used
`ifndef TOUCH_AVERAGE_CLAMP_SCALE_ASSERT_SVH
`define TOUCH_AVERAGE_CLAMP_SCALE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define TACS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define TACS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/tacs_pkg.sv =====
// shared widths, register codes and lane/divider structs for the touch averaging block
// no dependencies
package tacs_pkg;

    localparam int RAW_W  = 16;
    localparam int SPAN_W = 12;
    localparam int PROD_W = RAW_W + SPAN_W;
    localparam int IDX_W  = 3;

    typedef enum logic [IDX_W-1:0] {
        REG_RAW_X_LOW     = 3'd0,
        REG_RAW_X_HIGH    = 3'd1,
        REG_RAW_Y_LOW     = 3'd2,
        REG_RAW_Y_HIGH    = 3'd3,
        REG_SCREEN_WIDTH  = 3'd4,
        REG_SCREEN_HEIGHT = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic [RAW_W-1:0]  lo;
        logic [RAW_W-1:0]  hi;
        logic [SPAN_W-1:0] span;
    } lane_cfg_t;

    typedef struct packed {
        logic              done;
        logic [SPAN_W-1:0] result;
    } lane_status_t;

    typedef struct packed {
        logic              go;
        logic [PROD_W-1:0] num;
        logic [RAW_W-1:0]  den;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [PROD_W-1:0] quo;
    } div_rsp_t;

endpackage

// ===== rtl/tacs_div.sv =====
// serial restoring divider, one quotient bit per cycle
// depends on tacs_pkg
module tacs_div (
    input  logic               clk,
    input  logic               rst_n,
    input  tacs_pkg::div_req_t req,
    output tacs_pkg::div_rsp_t rsp
);

    localparam int CNT_W = $clog2(tacs_pkg::PROD_W + 1);

    logic                        busy_reg;
    logic                        done_reg;
    logic [CNT_W-1:0]            cnt_reg;
    logic [tacs_pkg::RAW_W-1:0]  rem_reg;
    logic [tacs_pkg::RAW_W-1:0]  den_reg;
    logic [tacs_pkg::PROD_W-1:0] quo_reg;

    logic [tacs_pkg::RAW_W:0]    trial;
    logic                        fits;
    logic [tacs_pkg::RAW_W:0]    rem_sub;
    logic [tacs_pkg::RAW_W-1:0]  rem_next;

    always_comb
    begin
        trial    = {rem_reg, quo_reg[tacs_pkg::PROD_W-1]};
        fits     = trial >= {1'b0, den_reg};
        rem_sub  = trial - {1'b0, den_reg};
        rem_next = fits ? rem_sub[tacs_pkg::RAW_W-1:0] : trial[tacs_pkg::RAW_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            den_reg  <= '0;
            quo_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.go)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                rem_reg  <= '0;
                den_reg  <= req.den;
                quo_reg  <= req.num;
            end
            else if (busy_reg)
            begin
                rem_reg <= rem_next;
                quo_reg <= {quo_reg[tacs_pkg::PROD_W-2:0], fits};
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(tacs_pkg::PROD_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;

endmodule

// ===== rtl/tacs_lane.sv =====
// one axis lane: average by reciprocal multiply, clamp to window, multiply by span, divide by window
// depends on tacs_pkg and tacs_div
module tacs_lane #(
    parameter int SAMPLES = 16
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          start,
    input  logic [tacs_pkg::RAW_W+$clog2(SAMPLES)-1:0]    sum,
    input  tacs_pkg::lane_cfg_t                           cfg,
    output tacs_pkg::lane_status_t                        status
);

    localparam int SUM_W  = tacs_pkg::RAW_W + $clog2(SAMPLES);
    localparam int LOG_S  = $clog2(SAMPLES);
    localparam int SHIFT  = SUM_W + LOG_S;
    localparam int RCP_W  = SUM_W + 1;
    localparam int AVG_PW = SUM_W + RCP_W;

    // rounded-up reciprocal of the window, exact for every sum that fits SUM_W bits
    localparam logic [63:0] RCP_FULL =
        ((64'd1 << SHIFT) + 64'(SAMPLES - 1)) / 64'(SAMPLES);
    localparam logic [RCP_W-1:0] RCP = RCP_FULL[RCP_W-1:0];

    typedef enum logic [2:0] {
        L_IDLE,
        L_AVG,
        L_CLAMP,
        L_MUL,
        L_SCALE,
        L_DONE
    } lane_state_t;

    lane_state_t                  state_reg;
    tacs_pkg::lane_cfg_t          cfg_reg;
    logic [SUM_W-1:0]             sum_reg;
    logic [tacs_pkg::RAW_W-1:0]   raw_reg;
    logic [tacs_pkg::RAW_W-1:0]   diff_reg;
    logic                         degen_reg;
    logic [tacs_pkg::SPAN_W-1:0]  result_reg;
    tacs_pkg::div_req_t           div_req_reg;
    tacs_pkg::div_rsp_t           div_rsp;

    logic [AVG_PW-1:0]            avg_prod;
    logic [tacs_pkg::RAW_W-1:0]   raw_lo;
    logic [tacs_pkg::RAW_W-1:0]   raw_clamp;

    assign avg_prod = AVG_PW'(sum_reg) * AVG_PW'(RCP);

    // raise to low first, then lower to high
    always_comb
    begin
        raw_lo    = (raw_reg < cfg_reg.lo) ? cfg_reg.lo : raw_reg;
        raw_clamp = (raw_lo > cfg_reg.hi) ? cfg_reg.hi : raw_lo;
    end

    tacs_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req_reg),
        .rsp   (div_rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= L_IDLE;
            cfg_reg     <= '0;
            sum_reg     <= '0;
            raw_reg     <= '0;
            diff_reg    <= '0;
            degen_reg   <= 1'b0;
            result_reg  <= '0;
            div_req_reg <= '0;
        end
        else
        begin
            div_req_reg.go <= 1'b0;
            case (state_reg)
                L_IDLE, L_DONE:
                begin
                    if (start)
                    begin
                        cfg_reg   <= cfg;
                        sum_reg   <= sum;
                        state_reg <= L_AVG;
                    end
                end
                L_AVG:
                begin
                    raw_reg   <= avg_prod[SHIFT +: tacs_pkg::RAW_W];
                    state_reg <= L_CLAMP;
                end
                L_CLAMP:
                begin
                    diff_reg        <= raw_clamp - cfg_reg.lo;
                    div_req_reg.den <= cfg_reg.hi - cfg_reg.lo;
                    degen_reg       <= cfg_reg.hi <= cfg_reg.lo;
                    state_reg       <= L_MUL;
                end
                L_MUL:
                begin
                    if (degen_reg)
                    begin
                        // empty or inverted window reads as zero
                        result_reg <= '0;
                        state_reg  <= L_DONE;
                    end
                    else
                    begin
                        div_req_reg.go  <= 1'b1;
                        div_req_reg.num <= tacs_pkg::PROD_W'(diff_reg) *
                                           tacs_pkg::PROD_W'(cfg_reg.span);
                        state_reg       <= L_SCALE;
                    end
                end
                L_SCALE:
                begin
                    if (div_rsp.done)
                    begin
                        result_reg <= div_rsp.quo[tacs_pkg::SPAN_W-1:0];
                        state_reg  <= L_DONE;
                    end
                end
                default:
                begin
                    state_reg <= L_IDLE;
                end
            endcase
        end
    end

    assign status.done   = (state_reg == L_DONE);
    assign status.result = result_reg;

endmodule

// ===== rtl/touch_average_clamp_scale.sv =====
// top level of the touch averaging block: accumulator, config registers, two axis lanes,
// merge into the output register; depends on tacs_pkg, tacs_lane and the assert header
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+------------------------------
//  in      | input     | in_valid / in_stall    | pressed, sample_x, sample_y
//  out     | output    | out_valid / out_stall  | ok, screen_x, screen_y
//  cfg     | input     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// a pressed beat that does not fill the window is added to the running sums
// a beat that fills the window starts both lanes; each lane averages by a constant
// reciprocal multiply, clamps, multiplies by the span and runs one serial division; the
// point lands once both lanes are done, sooner when both windows are empty or inverted
// a release beat loads a failure result directly into the output register
// every beat is stalled while the lanes run; a result-making beat is also stalled while a
// result waits, summing beats keep flowing then
// reset is asynchronous, active low; config registers come up at their documented values
module touch_average_clamp_scale #(
    parameter int SAMPLES = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          pressed,
    input  logic [tacs_pkg::RAW_W-1:0]    sample_x,
    input  logic [tacs_pkg::RAW_W-1:0]    sample_y,

    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          ok,
    output logic [tacs_pkg::SPAN_W-1:0]   screen_x,
    output logic [tacs_pkg::SPAN_W-1:0]   screen_y,

    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [tacs_pkg::IDX_W-1:0]    cfg_index,
    input  logic [tacs_pkg::RAW_W-1:0]    cfg_data
);

    localparam int SUM_W = tacs_pkg::RAW_W + $clog2(SAMPLES);
    localparam int CNT_W = $clog2(SAMPLES);

    // config registers
    logic [tacs_pkg::RAW_W-1:0]  raw_x_low_reg;
    logic [tacs_pkg::RAW_W-1:0]  raw_x_high_reg;
    logic [tacs_pkg::RAW_W-1:0]  raw_y_low_reg;
    logic [tacs_pkg::RAW_W-1:0]  raw_y_high_reg;
    logic [tacs_pkg::SPAN_W-1:0] screen_width_reg;
    logic [tacs_pkg::SPAN_W-1:0] screen_height_reg;

    // accumulator
    logic [SUM_W-1:0]            sum_x_reg;
    logic [SUM_W-1:0]            sum_y_reg;
    logic [CNT_W-1:0]            count_reg;
    logic [SUM_W-1:0]            sum_x_next;
    logic [SUM_W-1:0]            sum_y_next;

    // control and output register
    logic                        busy_reg;
    logic                        out_valid_reg;
    logic                        ok_reg;
    logic [tacs_pkg::SPAN_W-1:0] screen_x_reg;
    logic [tacs_pkg::SPAN_W-1:0] screen_y_reg;

    logic                        in_take;
    logic                        window_full;
    logic                        makes_result;
    logic                        lanes_start;
    logic                        lanes_done;

    tacs_pkg::lane_cfg_t         cfg_x;
    tacs_pkg::lane_cfg_t         cfg_y;
    tacs_pkg::lane_status_t      status_x;
    tacs_pkg::lane_status_t      status_y;

    assign cfg_ready = 1'b1;

    // this beat completes the window when the count already holds SAMPLES-1
    assign window_full  = (count_reg == CNT_W'(SAMPLES - 1));
    assign makes_result = !pressed || window_full;

    // result-making beats need the lanes idle and the output slot free
    assign in_stall = busy_reg || (out_valid_reg && makes_result);
    assign in_take  = in_valid && !in_stall;

    assign sum_x_next = sum_x_reg + {{(SUM_W - tacs_pkg::RAW_W){1'b0}}, sample_x};
    assign sum_y_next = sum_y_reg + {{(SUM_W - tacs_pkg::RAW_W){1'b0}}, sample_y};

    assign lanes_start = in_take && pressed && window_full;
    assign lanes_done  = busy_reg && status_x.done && status_y.done;

    assign cfg_x = '{lo: raw_x_low_reg, hi: raw_x_high_reg, span: screen_width_reg};
    assign cfg_y = '{lo: raw_y_low_reg, hi: raw_y_high_reg, span: screen_height_reg};

    tacs_lane #(
        .SAMPLES (SAMPLES)
    ) u_lane_x (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (lanes_start),
        .sum    (sum_x_next),
        .cfg    (cfg_x),
        .status (status_x)
    );

    tacs_lane #(
        .SAMPLES (SAMPLES)
    ) u_lane_y (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (lanes_start),
        .sum    (sum_y_next),
        .cfg    (cfg_y),
        .status (status_y)
    );

    // config writes; indexes past the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raw_x_low_reg     <= '0;
            raw_x_high_reg    <= '1;
            raw_y_low_reg     <= '0;
            raw_y_high_reg    <= '1;
            screen_width_reg  <= tacs_pkg::SPAN_W'(320);
            screen_height_reg <= tacs_pkg::SPAN_W'(240);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (tacs_pkg::reg_idx_t'(cfg_index))
                tacs_pkg::REG_RAW_X_LOW:     raw_x_low_reg     <= cfg_data;
                tacs_pkg::REG_RAW_X_HIGH:    raw_x_high_reg    <= cfg_data;
                tacs_pkg::REG_RAW_Y_LOW:     raw_y_low_reg     <= cfg_data;
                tacs_pkg::REG_RAW_Y_HIGH:    raw_y_high_reg    <= cfg_data;
                tacs_pkg::REG_SCREEN_WIDTH:  screen_width_reg  <= cfg_data[tacs_pkg::SPAN_W-1:0];
                tacs_pkg::REG_SCREEN_HEIGHT: screen_height_reg <= cfg_data[tacs_pkg::SPAN_W-1:0];
                default:                     ;
            endcase
        end
    end

    // accumulator, lane tracking and the merged output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_x_reg     <= '0;
            sum_y_reg     <= '0;
            count_reg     <= '0;
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            ok_reg        <= 1'b0;
            screen_x_reg  <= '0;
            screen_y_reg  <= '0;
        end
        else
        begin
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            if (in_take)
            begin
                if (!pressed)
                begin
                    // release: clear window, report contact lost
                    sum_x_reg     <= '0;
                    sum_y_reg     <= '0;
                    count_reg     <= '0;
                    out_valid_reg <= 1'b1;
                    ok_reg        <= 1'b0;
                    screen_x_reg  <= '0;
                    screen_y_reg  <= '0;
                end
                else if (window_full)
                begin
                    // lanes captured the final sums; start a fresh window
                    sum_x_reg <= '0;
                    sum_y_reg <= '0;
                    count_reg <= '0;
                    busy_reg  <= 1'b1;
                end
                else
                begin
                    sum_x_reg <= sum_x_next;
                    sum_y_reg <= sum_y_next;
                    count_reg <= count_reg + CNT_W'(1);
                end
            end

            // merge both axes once each lane has finished
            if (lanes_done)
            begin
                busy_reg      <= 1'b0;
                out_valid_reg <= 1'b1;
                ok_reg        <= 1'b1;
                screen_x_reg  <= status_x.result;
                screen_y_reg  <= status_y.result;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign ok        = ok_reg;
    assign screen_x  = screen_x_reg;
    assign screen_y  = screen_y_reg;

`include "touch_average_clamp_scale_assert.svh"

    `TACS_ASSERT_IMP(a_merge_only_when_busy, status_x.done && status_y.done && lanes_done, busy_reg && !out_valid_reg, "lanes merged while output slot was taken")
    `TACS_ASSERT_NEXT(a_release_reports_fail, in_take && !pressed, out_valid_reg && !ok_reg && count_reg == '0, "release beat did not load a failure result")
    `TACS_ASSERT_IMP(a_fail_is_zero, out_valid_reg && !ok_reg, screen_x_reg == '0 && screen_y_reg == '0, "failure result carries nonzero coordinates")
    `TACS_ASSERT_NEXT(a_full_starts_lanes, lanes_start, busy_reg && count_reg == '0 && sum_x_reg == '0, "full window did not start lanes and clear sums")

endmodule

// ===== sim/tb_touch_average_clamp_scale.sv =====
// self-checking bench for touch_average_clamp_scale: random touch beats, own averaging
// and calibration predictor, in-order result compare; depends on tacs_pkg and the rtl
`timescale 1ns / 1ps

module tb_touch_average_clamp_scale;

    localparam int HALF_PERIOD = 10;
    localparam int WINDOW      = 16;                      // samples per averaged point
    localparam int SUM_W       = tacs_pkg::RAW_W + $clog2(WINDOW);
    localparam int SETTLE      = 100;                     // idle margin, longer than a lane run
    localparam int PHASES      = 12;
    localparam int PHASE_BEATS = 150;
    localparam int GAP_PCT     = 12;

    // indexes past the register list, writes there must change nothing
    localparam logic [tacs_pkg::IDX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [tacs_pkg::IDX_W-1:0] REG_SPARE_B = 3'd7;

    typedef struct packed {
        logic                       pressed;
        logic [tacs_pkg::RAW_W-1:0] x;
        logic [tacs_pkg::RAW_W-1:0] y;
    } touch_beat_t;

    typedef struct packed {
        logic                        ok;
        logic [tacs_pkg::SPAN_W-1:0] x;
        logic [tacs_pkg::SPAN_W-1:0] y;
    } screen_point_t;

    logic                        clk       = 1'b0;
    logic                        rst_n     = 1'b0;
    logic                        in_valid  = 1'b0;
    logic                        in_stall;
    logic                        pressed   = 1'b0;
    logic [tacs_pkg::RAW_W-1:0]  sample_x  = '0;
    logic [tacs_pkg::RAW_W-1:0]  sample_y  = '0;
    logic                        out_valid;
    logic                        out_stall = 1'b0;
    logic                        ok;
    logic [tacs_pkg::SPAN_W-1:0] screen_x;
    logic [tacs_pkg::SPAN_W-1:0] screen_y;
    logic                        cfg_valid = 1'b0;
    logic                        cfg_ready;
    logic [tacs_pkg::IDX_W-1:0]  cfg_index = '0;
    logic [tacs_pkg::RAW_W-1:0]  cfg_data  = '0;

    // beats waiting for the driver and points the block still owes us
    touch_beat_t   beat_q[$];
    screen_point_t point_q[$];
    touch_beat_t   shown_beat;
    int            errors  = 0;
    bit            idle_on = 1'b1;

    // predictor copy of the calibration registers, reset values
    logic [tacs_pkg::RAW_W-1:0]  x_lo   = '0;
    logic [tacs_pkg::RAW_W-1:0]  x_hi   = '1;
    logic [tacs_pkg::RAW_W-1:0]  y_lo   = '0;
    logic [tacs_pkg::RAW_W-1:0]  y_hi   = '1;
    logic [tacs_pkg::SPAN_W-1:0] span_x = tacs_pkg::SPAN_W'(320);
    logic [tacs_pkg::SPAN_W-1:0] span_y = tacs_pkg::SPAN_W'(240);

    // predictor copy of the running sums
    logic [SUM_W-1:0]  acc_x     = '0;
    logic [SUM_W-1:0]  acc_y     = '0;
    int                acc_count = 0;

    always #(HALF_PERIOD) clk = ~clk;

    touch_average_clamp_scale #(
        .SAMPLES   (WINDOW)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .pressed   (pressed),
        .sample_x  (sample_x),
        .sample_y  (sample_y),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .ok        (ok),
        .screen_x  (screen_x),
        .screen_y  (screen_y),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // average by the window, clamp into [lo, hi], then map onto 0..span
    function automatic logic [tacs_pkg::SPAN_W-1:0] map_axis(
        input logic [SUM_W-1:0]            total,
        input logic [tacs_pkg::RAW_W-1:0]  lo,
        input logic [tacs_pkg::RAW_W-1:0]  hi,
        input logic [tacs_pkg::SPAN_W-1:0] span);
        logic [tacs_pkg::RAW_W-1:0]  avg;
        logic [tacs_pkg::PROD_W-1:0] prod;
        avg = tacs_pkg::RAW_W'(total / WINDOW);
        if (avg < lo)
            avg = lo;
        if (avg > hi)
            avg = hi;
        // empty or inverted window gives zero
        if (hi <= lo)
            return '0;
        prod = tacs_pkg::PROD_W'(avg - lo) * tacs_pkg::PROD_W'(span);
        return tacs_pkg::SPAN_W'(prod / tacs_pkg::PROD_W'(hi - lo));
    endfunction

    // one accepted beat: release always reports a lost contact, a full window a point
    function automatic void track_beat(input touch_beat_t b);
        screen_point_t pt;
        if (!b.pressed)
        begin
            acc_x     = '0;
            acc_y     = '0;
            acc_count = 0;
            pt        = '{1'b0, '0, '0};
            point_q.push_back(pt);
        end
        else
        begin
            acc_x     = acc_x + SUM_W'(b.x);
            acc_y     = acc_y + SUM_W'(b.y);
            acc_count = acc_count + 1;
            if (acc_count == WINDOW)
            begin
                pt.ok     = 1'b1;
                pt.x      = map_axis(acc_x, x_lo, x_hi, span_x);
                pt.y      = map_axis(acc_y, y_lo, y_hi, span_y);
                point_q.push_back(pt);
                acc_x     = '0;
                acc_y     = '0;
                acc_count = 0;
            end
        end
    endfunction

    // spans keep only their low 12 bits, unknown indexes are dropped
    function automatic void apply_reg(input logic [tacs_pkg::IDX_W-1:0] idx,
                                      input logic [tacs_pkg::RAW_W-1:0] data);
        case (idx)
            tacs_pkg::REG_RAW_X_LOW:     x_lo   = data;
            tacs_pkg::REG_RAW_X_HIGH:    x_hi   = data;
            tacs_pkg::REG_RAW_Y_LOW:     y_lo   = data;
            tacs_pkg::REG_RAW_Y_HIGH:    y_hi   = data;
            tacs_pkg::REG_SCREEN_WIDTH:  span_x = data[tacs_pkg::SPAN_W-1:0];
            tacs_pkg::REG_SCREEN_HEIGHT: span_y = data[tacs_pkg::SPAN_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic bit take_gap();
        return idle_on && ($urandom_range(99) < GAP_PCT);
    endfunction

    // ------------------------------------------------------------------
    // input driver: holds a stalled beat, otherwise pulls the next one or idles
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            pressed  <= 1'b0;
            sample_x <= '0;
            sample_y <= '0;
        end
        else if (!(in_valid && in_stall))
        begin
            // beat taken at this edge goes to the predictor first
            if (in_valid)
                track_beat(shown_beat);
            if (beat_q.size() > 0 && !take_gap())
            begin
                shown_beat = beat_q.pop_front();
                in_valid  <= 1'b1;
                pressed   <= shown_beat.pressed;
                sample_x  <= shown_beat.x;
                sample_y  <= shown_beat.y;
            end
            else
            begin
                in_valid  <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // output monitor: compares every taken result beat against the oldest point
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : watch_out
        screen_point_t want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (point_q.size() == 0)
                begin
                    $error("result beat with no point pending: ok %0d x %0d y %0d",
                           ok, screen_x, screen_y);
                    errors++;
                end
                else
                begin
                    want = point_q.pop_front();
                    if (ok !== want.ok)
                    begin
                        $error("ok mismatch: expected %0d, actual %0d", want.ok, ok);
                        errors++;
                    end
                    if (screen_x !== want.x)
                    begin
                        $error("screen_x mismatch: expected %0d, actual %0d",
                               want.x, screen_x);
                        errors++;
                    end
                    if (screen_y !== want.y)
                    begin
                        $error("screen_y mismatch: expected %0d, actual %0d",
                               want.y, screen_y);
                        errors++;
                    end
                end
            end
            out_stall <= take_gap();
        end
    end

    // ------------------------------------------------------------------
    // config writes, only called while the block is drained
    // ------------------------------------------------------------------
    task automatic write_reg(input logic [tacs_pkg::IDX_W-1:0] idx,
                             input logic [tacs_pkg::RAW_W-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        apply_reg(idx, data);
    endtask

    // span beat with junk in the unused top nibble
    function automatic logic [tacs_pkg::RAW_W-1:0] span_word(
        input logic [tacs_pkg::SPAN_W-1:0] span);
        return {4'($urandom_range(15)), span};
    endfunction

    function automatic logic [tacs_pkg::SPAN_W-1:0] draw_span();
        case ($urandom_range(9))
            0:       return '0;
            1:       return tacs_pkg::SPAN_W'(1);
            2:       return '1;
            default: return tacs_pkg::SPAN_W'($urandom_range(4095, 1));
        endcase
    endfunction

    // mostly ordered windows, some empty, inverted or full-range
    task automatic draw_window(output logic [tacs_pkg::RAW_W-1:0] lo,
                               output logic [tacs_pkg::RAW_W-1:0] hi);
        logic [tacs_pkg::RAW_W-1:0] a;
        logic [tacs_pkg::RAW_W-1:0] b;
        a = tacs_pkg::RAW_W'($urandom());
        b = tacs_pkg::RAW_W'($urandom());
        case ($urandom_range(9))
            0:
            begin
                lo = a;
                hi = a;
            end
            1:
            begin
                lo = (a > b) ? a : b;
                hi = (a > b) ? b : a;
            end
            2:
            begin
                lo = '0;
                hi = '1;
            end
            default:
            begin
                lo = (a < b) ? a : b;
                hi = (a < b) ? b : a;
            end
        endcase
    endtask

    // first phases pin the corner settings, the rest draw at random
    task automatic configure_phase(input int phase);
        logic [tacs_pkg::RAW_W-1:0]  xl;
        logic [tacs_pkg::RAW_W-1:0]  xh;
        logic [tacs_pkg::RAW_W-1:0]  yl;
        logic [tacs_pkg::RAW_W-1:0]  yh;
        logic [tacs_pkg::SPAN_W-1:0] sw;
        logic [tacs_pkg::SPAN_W-1:0] sh;
        case (phase)
            0:
            begin
                // full raw range, widest screen
                xl = '0;  xh = '1;  yl = '0;  yh = '1;
                sw = '1;  sh = '1;
            end
            1:
            begin
                // inverted x window, empty y window, unit spans
                xl = 16'hC000;  xh = 16'h4000;  yl = 16'h8000;  yh = 16'h8000;
                sw = tacs_pkg::SPAN_W'(1);  sh = tacs_pkg::SPAN_W'(1);
            end
            2:
            begin
                // narrowest windows at both ends, zero spans
                xl = 16'hFFFE;  xh = '1;  yl = '0;  yh = 16'h0001;
                sw = '0;  sh = '0;
            end
            3:
            begin
                // fully inverted y, mixed spans
                xl = '0;  xh = '1;  yl = '1;  yh = '0;
                sw = '1;  sh = tacs_pkg::SPAN_W'(1);
            end
            default:
            begin
                draw_window(xl, xh);
                draw_window(yl, yh);
                sw = draw_span();
                sh = draw_span();
            end
        endcase
        write_reg(tacs_pkg::REG_RAW_X_LOW, xl);
        write_reg(tacs_pkg::REG_RAW_X_HIGH, xh);
        write_reg(tacs_pkg::REG_RAW_Y_LOW, yl);
        write_reg(tacs_pkg::REG_RAW_Y_HIGH, yh);
        write_reg(tacs_pkg::REG_SCREEN_WIDTH, span_word(sw));
        write_reg(tacs_pkg::REG_SCREEN_HEIGHT, span_word(sh));
        // stray writes after the real ones so any aliasing shows up
        if (phase == 0 || $urandom_range(1))
            write_reg(REG_SPARE_A, tacs_pkg::RAW_W'($urandom()));
        if (phase == 0 || $urandom_range(1))
            write_reg(REG_SPARE_B, tacs_pkg::RAW_W'($urandom()));
    endtask

    // ------------------------------------------------------------------
    // stimulus building
    // ------------------------------------------------------------------
    function automatic logic [tacs_pkg::RAW_W-1:0] near(
        input logic [tacs_pkg::RAW_W-1:0] center,
        input int                         spread);
        int v;
        v = int'(center) + int'($urandom_range(2 * spread)) - spread;
        if (v < 0)
            v = 0;
        if (v > 65535)
            v = 65535;
        return tacs_pkg::RAW_W'(v);
    endfunction

    function automatic logic [tacs_pkg::RAW_W-1:0] pick_center();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            default: return tacs_pkg::RAW_W'($urandom());
        endcase
    endfunction

    // a burst of pressed beats clustered around one point
    task automatic push_presses(input int count, input int spread);
        logic [tacs_pkg::RAW_W-1:0] cx;
        logic [tacs_pkg::RAW_W-1:0] cy;
        cx = pick_center();
        cy = pick_center();
        for (int i = 0; i < count; i++)
            beat_q.push_back('{1'b1, near(cx, spread), near(cy, spread)});
    endtask

    // release carries random readings, the block must ignore them
    task automatic push_release();
        beat_q.push_back('{1'b0, tacs_pkg::RAW_W'($urandom()), tacs_pkg::RAW_W'($urandom())});
    endtask

    // mostly complete windows; some cut short by a release, some lone releases
    task automatic queue_sequence(output int added);
        int r;
        int spread;
        int cut;
        r = $urandom_range(99);
        case ($urandom_range(3))
            0:       spread = 0;
            1:       spread = 64;
            2:       spread = 4096;
            default: spread = 65535;
        endcase
        if (r < 80)
        begin
            push_presses(WINDOW, spread);
            added = WINDOW;
        end
        else if (r < 92)
        begin
            cut = $urandom_range(WINDOW - 1, 1);
            push_presses(cut, spread);
            push_release();
            added = cut + 1;
        end
        else
        begin
            push_release();
            added = 1;
        end
    endtask

    // everything sent, everything back, then let a stray late point show itself
    task automatic wait_drained();
        do
            @(posedge clk);
        while (beat_q.size() != 0 || in_valid || point_q.size() != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin : run
        int count;
        int added;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed: release with nothing summed, one window at opposite extremes,
        // then a window broken by a release, all at reset calibration
        push_release();
        for (int i = 0; i < WINDOW; i++)
            beat_q.push_back('{1'b1, 16'hFFFF, 16'h0000});
        for (int i = 0; i < 3; i++)
            beat_q.push_back('{1'b1, 16'h0000, 16'hFFFF});
        push_release();
        wait_drained();

        for (int p = 0; p < PHASES; p++)
        begin
            configure_phase(p);
            // one phase runs with both sides at full rate
            idle_on = (p != 4);
            count   = 0;
            while (count < PHASE_BEATS)
            begin
                queue_sequence(added);
                count += added;
            end
            wait_drained();
        end

        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // hang guard, far beyond the slowest legal run
    initial
    begin
        #(64'd20_000_000);
        $display("FAIL");
        $finish;
    end

endmodule
